### hdl/mbd_pkg.sv
// Shared types, codes and constants of the multipart boundary deframer.
// No dependencies; every other file refers to it by scoped names.
package mbd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_BOUNDARY_DEF    = 50;
  localparam int MAX_TRAIL_SPACE_DEF = 1;

  // Queue sizes between the parts
  localparam int IQ_DEPTH = 2;
  localparam int IQ_PW    = 1;
  localparam int IQ_CW    = 2;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = 2;
  localparam int OQ_CW    = 3;

  // Configuration port
  localparam int APB_AW = 3;
  localparam logic REG_BLEN   = 1'b0;
  localparam logic REG_NLMODE = 1'b1;

  // Operation codes of an input item
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // Region and event codes of a result
  localparam logic [1:0] RG_HDR   = 2'd0;
  localparam logic [1:0] RG_BODY  = 2'd1;
  localparam logic [1:0] RG_EVENT = 2'd2;
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_SEP   = 3'd1;
  localparam logic [2:0] EV_TERM  = 3'd2;
  localparam logic [2:0] EV_HDRS  = 3'd3;
  localparam logic [2:0] EV_END   = 3'd4;

  // Characters
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_DASH = 8'd45;

  typedef enum logic [1:0] {K_LOAD, K_BYTE, K_END, K_NONE} kind_e;
  typedef enum logic [1:0] {PH_PRE, PH_HDR, PH_BODY, PH_EPI} phase_e;
  typedef enum logic [2:0] {M_FETCH, M_OPEN, M_PITEM, M_REPLAY, M_END} mode_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [5:0] boundary_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] region;
    logic [2:0] event_res;
    logic       closed_part;
    logic       last;
  } out_item_t;

  // Classified item handed from front to engine
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [5:0] idx;
  } cls_t;

  // One result without its last flag
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] region;
    logic [2:0] event_res;
    logic       closed_part;
  } res_t;

  // Engine to output stage
  typedef struct packed {
    logic emit;
    logic done;
    res_t res;
  } eng_out_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9) || (c == 8'd11) || (c == 8'd12) || (c == CH_CR);
  endfunction

endpackage

### hdl/multipart_boundary_deframer_top.sv
// Multipart boundary deframer: stream bytes pass the front queue into the engine; a byte result
// is held, then queued, in the output stage; the engine finishes an item before taking the next.
// A failed boundary match replays its held bytes, also where the preamble drops them.
// Reset clears the walk to the preamble; boundary_length 0, newline_mode 1.
// Boundary text is undefined until loaded; there is no clearing pass.
// Top level: configuration registers and the front, engine and output stage.
module multipart_boundary_deframer_top #(
  parameter int MAX_BOUNDARY    = mbd_pkg::MAX_BOUNDARY_DEF,
  parameter int MAX_TRAIL_SPACE = mbd_pkg::MAX_TRAIL_SPACE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  mbd_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output mbd_pkg::out_item_t           out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbd_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [5:0]        blen_q;
  logic              nl_mode_q;
  logic              wr;
  logic              hd_valid, pop, out_ok;
  mbd_pkg::cls_t     hd;
  mbd_pkg::eng_out_t eo;

  // Configuration registers
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q    <= 6'd0;
      nl_mode_q <= 1'b1;
    end else if (wr) begin
      if (paddr[2] == mbd_pkg::REG_BLEN) blen_q <= pwdata[5:0];
      else nl_mode_q <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == mbd_pkg::REG_NLMODE) ? {31'd0, nl_mode_q} : {26'd0, blen_q};

  mbd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .hd_valid_o (hd_valid), .hd_o (hd), .pop_i (pop)
  );

  mbd_engine #(
    .MAX_BOUNDARY    (MAX_BOUNDARY),
    .MAX_TRAIL_SPACE (MAX_TRAIL_SPACE)
  ) u_engine (
    .clk_i, .rst_ni, .hd_valid_i (hd_valid), .hd_i (hd), .pop_o (pop),
    .out_ok_i (out_ok), .blen_i (blen_q), .nl_mode_i (nl_mode_q), .eo_o (eo)
  );

  mbd_outq u_outq (
    .clk_i, .rst_ni, .eo_i (eo), .out_ok_o (out_ok),
    .out_valid_o, .out_ready_i, .out_item_o
  );

endmodule

### hdl/mbd_front.sv
// Front part: input queue that accepts items and classifies their operation.
// Depends on mbd_pkg.
module mbd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mbd_pkg::in_item_t in_item_i,
  output logic              hd_valid_o,
  output mbd_pkg::cls_t     hd_o,
  input  logic              pop_i
);

  mbd_pkg::cls_t                 ent_q [mbd_pkg::IQ_DEPTH];
  mbd_pkg::cls_t                 cls;
  logic [mbd_pkg::IQ_PW-1:0]     wptr_q, rptr_q;
  logic [mbd_pkg::IQ_CW-1:0]     cnt_q, cnt_d;
  logic                          push;

  // Classify the operation
  always_comb begin
    cls.data = in_item_i.data_byte;
    cls.idx  = in_item_i.boundary_index;
    unique case (in_item_i.operation)
      mbd_pkg::OP_LOAD: cls.kind = mbd_pkg::K_LOAD;
      mbd_pkg::OP_BYTE: cls.kind = mbd_pkg::K_BYTE;
      mbd_pkg::OP_END:  cls.kind = mbd_pkg::K_END;
      default:          cls.kind = mbd_pkg::K_NONE;
    endcase
  end

  assign in_ready_o = (cnt_q != mbd_pkg::IQ_CW'(mbd_pkg::IQ_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign hd_valid_o = (cnt_q != '0);
  assign hd_o       = ent_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push && pop_i) cnt_d = cnt_q - 1'b1;
  end

  // Store the classified item
  always_ff @(posedge clk_i) begin
    if (push) ent_q[wptr_q] <= cls;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop_i) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hdl/mbd_engine.sv
// Back part: line walk, boundary matching, replay of held bytes, events.
// Holds the boundary text memory. Depends on mbd_pkg.
module mbd_engine #(
  parameter int MAX_BOUNDARY    = mbd_pkg::MAX_BOUNDARY_DEF,
  parameter int MAX_TRAIL_SPACE = mbd_pkg::MAX_TRAIL_SPACE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                hd_valid_i,
  input  mbd_pkg::cls_t       hd_i,
  output logic                pop_o,
  input  logic                out_ok_i,
  input  logic [5:0]          blen_i,
  input  logic                nl_mode_i,
  output mbd_pkg::eng_out_t   eo_o
);

  localparam int AW       = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;
  localparam int HS_DEPTH = (MAX_TRAIL_SPACE > 0) ? MAX_TRAIL_SPACE : 1;
  localparam int HS_IW    = (HS_DEPTH > 1) ? $clog2(HS_DEPTH) : 1;
  localparam logic [5:0] MAXB = 6'(MAX_BOUNDARY);
  localparam logic [3:0] MTS  = 4'(MAX_TRAIL_SPACE);

  // State
  mbd_pkg::phase_e phase_q, phase_d;
  mbd_pkg::mode_e  mode_q, mode_d;
  logic       line_start_q, line_start_d, cand_q, cand_d;
  logic [5:0] mp_q, mp_d;
  logic [1:0] td_q, td_d;
  logic [3:0] ts_q, ts_d;
  logic       hcr_q, hcr_d, first_q, first_d, blank_q, blank_d, pend_q, pend_d;
  logic       nl_sent_q, nl_sent_d, open_rep_q, open_rep_d, rep_end_q, rep_end_d;
  logic [5:0] r_q, r_d;
  logic [5:0] b1_q, b1_d, b2_q, b2_d, b3_q, b3_d, tot_q, tot_d;
  logic [7:0] cur_c_q, cur_c_d;
  logic [7:0] hs_q [HS_DEPTH];
  logic [7:0] hs_d [HS_DEPTH];

  // Boundary memory
  logic [7:0]    mem [MAX_BOUNDARY];
  logic [7:0]    rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic [5:0]    rsrc;
  logic          we;

  // Working signals
  logic [5:0] eff, full;
  logic [7:0] c, exp_c, rb, p_c;
  logic       nb, p_blank;
  logic       pl_emit, pl_stay, pl_end, pl_set_hcr, pl_clr_hcr;
  logic [1:0] pl_rg;
  logic [7:0] pl_byte;
  logic       use_plain, do_end, do_hit, do_fin, do_rep, rep_end_set, fail, ok;
  logic [3:0] ts1, ts_v;
  logic       hcr1, hcr_v;
  logic       em, pop, act_item;
  mbd_pkg::res_t em_res;
  logic [HS_IW-1:0] hsi;
  logic [5:0] hs_off;

  assign eff  = (blen_i > MAXB) ? MAXB : blen_i;
  assign full = eff + 6'd2;
  assign c    = hd_i.data;
  assign nb   = (phase_q == mbd_pkg::PH_HDR) && ((c == mbd_pkg::CH_CR) || (c == mbd_pkg::CH_LF));
  assign exp_c = (mp_q < 6'd2) ? mbd_pkg::CH_DASH : rdata_q;

  // Select the replay byte
  assign hs_off = r_q - b2_q;
  assign hsi    = hs_off[HS_IW-1:0];
  always_comb begin
    if (r_q < 6'd2) rb = mbd_pkg::CH_DASH;
    else if (r_q < b1_q) rb = rdata_q;
    else if (r_q < b2_q) rb = mbd_pkg::CH_DASH;
    else if (r_q < b3_q) rb = hs_q[hsi];
    else rb = mbd_pkg::CH_CR;
  end

  // Byte and blank flag seen by the plain line handler
  always_comb begin
    unique case (mode_q)
      mbd_pkg::M_REPLAY: p_c = rb;
      mbd_pkg::M_PITEM:  p_c = cur_c_q;
      default:           p_c = c;
    endcase
    p_blank = (mode_q == mbd_pkg::M_FETCH && line_start_q) ? nb : blank_q;
  end

  // Plain line handling of one byte
  always_comb begin
    pl_emit = 1'b0; pl_stay = 1'b0; pl_end = 1'b0; pl_set_hcr = 1'b0; pl_clr_hcr = 1'b0;
    pl_byte = p_c; pl_rg = mbd_pkg::RG_BODY;
    unique case (phase_q)
      mbd_pkg::PH_HDR: begin
        pl_emit = 1'b1;
        pl_rg   = mbd_pkg::RG_HDR;
        pl_end  = (p_c == mbd_pkg::CH_LF);
      end
      mbd_pkg::PH_BODY: begin
        if (hcr_q) begin
          if (p_c == mbd_pkg::CH_LF) pl_end = 1'b1;
          else begin
            pl_emit = 1'b1; pl_byte = mbd_pkg::CH_CR; pl_clr_hcr = 1'b1; pl_stay = 1'b1;
          end
        end else if (p_c == mbd_pkg::CH_LF) pl_end = 1'b1;
        else if (p_c == mbd_pkg::CH_CR) pl_set_hcr = 1'b1;
        else pl_emit = 1'b1;
      end
      mbd_pkg::PH_PRE: pl_end = (p_c == mbd_pkg::CH_LF);
      default: ;
    endcase
  end

  // Main sequencer
  always_comb begin
    phase_d = phase_q; mode_d = mode_q; line_start_d = line_start_q; cand_d = cand_q;
    mp_d = mp_q; td_d = td_q; ts_d = ts_q; hcr_d = hcr_q; first_d = first_q;
    blank_d = blank_q; pend_d = pend_q; nl_sent_d = nl_sent_q; open_rep_d = open_rep_q;
    rep_end_d = rep_end_q; r_d = r_q; b1_d = b1_q; b2_d = b2_q; b3_d = b3_q; tot_d = tot_q;
    cur_c_d = cur_c_q;
    for (int i = 0; i < HS_DEPTH; i++) hs_d[i] = hs_q[i];
    pop = 1'b0; em = 1'b0; em_res = '0; we = 1'b0;
    use_plain = 1'b0; do_end = 1'b0; do_hit = 1'b0; do_fin = 1'b0; do_rep = 1'b0;
    rep_end_set = 1'b0; fail = 1'b0; ok = 1'b0;
    ts1 = ts_q; hcr1 = hcr_q; ts_v = ts_q; hcr_v = hcr_q;

    if (out_ok_i) begin
      if (pend_q) begin
        // Emit the pending headers-complete event
        em = 1'b1;
        em_res = '{out_byte: 8'd0, region: mbd_pkg::RG_EVENT,
                   event_res: mbd_pkg::EV_HDRS, closed_part: 1'b0};
        pend_d = 1'b0;
      end else begin
        unique case (mode_q)
          mbd_pkg::M_FETCH: begin
            if (hd_valid_i) begin
              unique case (hd_i.kind)
                mbd_pkg::K_LOAD: begin
                  pop = 1'b1;
                  we  = (hd_i.idx < MAXB);
                end
                mbd_pkg::K_NONE: pop = 1'b1;
                mbd_pkg::K_BYTE: begin
                  if (phase_q == mbd_pkg::PH_EPI) pop = 1'b1;
                  else if (line_start_q) begin
                    pop = 1'b1;
                    line_start_d = 1'b0;
                    if (eff != 6'd0 && c == mbd_pkg::CH_DASH) begin
                      cand_d = 1'b1; mp_d = 6'd1; td_d = '0; ts_d = '0; hcr_d = 1'b0;
                    end else begin
                      blank_d = nb;
                      if (phase_q == mbd_pkg::PH_BODY) first_d = 1'b0;
                      if (phase_q == mbd_pkg::PH_BODY && !first_q) begin
                        cur_c_d = c; mode_d = mbd_pkg::M_OPEN;
                        open_rep_d = 1'b0; nl_sent_d = 1'b0;
                      end else use_plain = 1'b1;
                    end
                  end else if (cand_q) begin
                    // Match one byte of a possible boundary line
                    pop = 1'b1;
                    if (mp_q < full) begin
                      if (c == exp_c) mp_d = mp_q + 6'd1;
                      else fail = 1'b1;
                    end else if (c == mbd_pkg::CH_DASH && td_q < 2'd2 && ts_q == '0 && !hcr_q) begin
                      td_d = td_q + 2'd1;
                    end else if (c == mbd_pkg::CH_LF) begin
                      if (td_q != 2'd1) do_hit = 1'b1;
                      else fail = 1'b1;
                    end else if (mbd_pkg::is_ws(c) && td_q != 2'd1) begin
                      ok = !hcr_q || (ts_q < MTS);
                      if (hcr_q && ok) begin
                        hs_d[ts_q[HS_IW-1:0]] = mbd_pkg::CH_CR;
                        ts1 = ts_q + 4'd1;
                      end
                      if (ok) hcr1 = 1'b0;
                      if (!ok) fail = 1'b1;
                      else if (c == mbd_pkg::CH_CR) begin
                        ts_d = ts1; hcr_d = 1'b1;
                      end else if (ts1 < MTS) begin
                        hs_d[ts1[HS_IW-1:0]] = c;
                        ts_d = ts1 + 4'd1; hcr_d = 1'b0;
                      end else begin
                        ts_v = ts1; hcr_v = hcr1; fail = 1'b1;
                      end
                    end else fail = 1'b1;
                    if (fail) begin
                      do_rep = 1'b1; cur_c_d = c;
                    end
                  end else begin
                    use_plain = 1'b1;
                    pop = !pl_stay;
                  end
                end
                mbd_pkg::K_END: begin
                  pop = 1'b1;
                  if (phase_q == mbd_pkg::PH_EPI || line_start_q) do_fin = 1'b1;
                  else if (cand_q) begin
                    if (mp_q >= full && td_q != 2'd1) begin
                      do_hit = 1'b1; mode_d = mbd_pkg::M_END;
                    end else begin
                      do_rep = 1'b1; rep_end_set = 1'b1;
                    end
                  end else mode_d = mbd_pkg::M_END;
                end
                default: ;
              endcase
            end
          end
          mbd_pkg::M_OPEN: begin
            // Put the newline in front of a body line
            em = 1'b1;
            em_res = '{out_byte: mbd_pkg::CH_LF, region: mbd_pkg::RG_BODY,
                       event_res: mbd_pkg::EV_NONE, closed_part: 1'b0};
            if (nl_mode_i && !nl_sent_q) begin
              em_res.out_byte = mbd_pkg::CH_CR;
              nl_sent_d = 1'b1;
            end else begin
              mode_d = open_rep_q ? mbd_pkg::M_REPLAY : mbd_pkg::M_PITEM;
            end
          end
          mbd_pkg::M_PITEM: begin
            use_plain = 1'b1;
            if (!pl_stay) mode_d = mbd_pkg::M_FETCH;
          end
          mbd_pkg::M_REPLAY: begin
            use_plain = 1'b1;
            if (!pl_stay) begin
              r_d = r_q + 6'd1;
              if (r_q + 6'd1 == tot_q) mode_d = rep_end_q ? mbd_pkg::M_END : mbd_pkg::M_PITEM;
            end
          end
          mbd_pkg::M_END: begin
            if (!line_start_q) do_end = 1'b1;
            else do_fin = 1'b1;
          end
          default: ;
        endcase
      end
    end

    // Apply the plain handler
    if (use_plain) begin
      if (pl_emit) begin
        em = 1'b1;
        em_res = '{out_byte: pl_byte, region: pl_rg,
                   event_res: mbd_pkg::EV_NONE, closed_part: 1'b0};
      end
      if (pl_set_hcr) hcr_d = 1'b1;
      if (pl_clr_hcr) hcr_d = 1'b0;
      if (pl_end) do_end = 1'b1;
    end

    // End a line
    if (do_end) begin
      line_start_d = 1'b1; cand_d = 1'b0; mp_d = '0; td_d = '0; ts_d = '0; hcr_d = 1'b0;
      if (phase_q == mbd_pkg::PH_HDR && p_blank) begin
        pend_d = 1'b1; phase_d = mbd_pkg::PH_BODY; first_d = 1'b1;
      end
      blank_d = 1'b0;
    end

    // Boundary line found
    if (do_hit) begin
      em = 1'b1;
      em_res = '{out_byte: 8'd0, region: mbd_pkg::RG_EVENT,
                 event_res: (td_q == 2'd2) ? mbd_pkg::EV_TERM : mbd_pkg::EV_SEP,
                 closed_part: (phase_q != mbd_pkg::PH_PRE)};
      cand_d = 1'b0; mp_d = '0; td_d = '0; ts_d = '0; hcr_d = 1'b0;
      line_start_d = 1'b1; blank_d = 1'b0;
      phase_d = (td_q == 2'd2) ? mbd_pkg::PH_EPI : mbd_pkg::PH_HDR;
    end

    // Match failed: snapshot and start replay
    if (do_rep) begin
      b1_d  = mp_q;
      b2_d  = mp_q + {4'd0, td_q};
      b3_d  = b2_d + {2'd0, ts_v};
      tot_d = b3_d + {5'd0, hcr_v};
      r_d   = '0;
      cand_d = 1'b0; mp_d = '0; td_d = '0; ts_d = '0; hcr_d = 1'b0;
      blank_d = 1'b0;
      rep_end_d = rep_end_set;
      open_rep_d = 1'b1; nl_sent_d = 1'b0;
      if (phase_q == mbd_pkg::PH_BODY) first_d = 1'b0;
      mode_d = (phase_q == mbd_pkg::PH_BODY && !first_q) ? mbd_pkg::M_OPEN : mbd_pkg::M_REPLAY;
    end

    // Stream end event and walk reset
    if (do_fin) begin
      em = 1'b1;
      em_res = '{out_byte: 8'd0, region: mbd_pkg::RG_EVENT, event_res: mbd_pkg::EV_END,
                 closed_part: (phase_q == mbd_pkg::PH_BODY)};
      phase_d = mbd_pkg::PH_PRE; line_start_d = 1'b1;
      cand_d = 1'b0; mp_d = '0; td_d = '0; ts_d = '0; hcr_d = 1'b0;
      first_d = 1'b1; blank_d = 1'b0; mode_d = mbd_pkg::M_FETCH;
    end
  end

  // Item is finished when nothing of it is left to do
  assign act_item   = out_ok_i && (pend_q || (mode_q != mbd_pkg::M_FETCH) || pop);
  assign eo_o.emit  = em;
  assign eo_o.res   = em_res;
  assign eo_o.done  = act_item && (mode_d == mbd_pkg::M_FETCH) && !pend_d;
  assign pop_o      = pop;

  // Prefetch the boundary byte needed next
  assign rsrc  = ((mode_d == mbd_pkg::M_REPLAY) ? r_d : mp_d) - 6'd2;
  assign raddr = rsrc[AW-1:0];
  assign waddr = hd_i.idx[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= hd_i.data;
    rdata_q <= (we && waddr == raddr) ? hd_i.data : mem[raddr];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_c_q <= cur_c_d;
    b1_q <= b1_d; b2_q <= b2_d; b3_q <= b3_d; tot_q <= tot_d;
    for (int i = 0; i < HS_DEPTH; i++) hs_q[i] <= hs_d[i];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mbd_pkg::PH_PRE; mode_q <= mbd_pkg::M_FETCH;
      line_start_q <= 1'b1; cand_q <= 1'b0; mp_q <= '0; td_q <= '0; ts_q <= '0;
      hcr_q <= 1'b0; first_q <= 1'b1; blank_q <= 1'b0; pend_q <= 1'b0;
      nl_sent_q <= 1'b0; open_rep_q <= 1'b0; rep_end_q <= 1'b0; r_q <= '0;
    end else begin
      phase_q <= phase_d; mode_q <= mode_d;
      line_start_q <= line_start_d; cand_q <= cand_d; mp_q <= mp_d; td_q <= td_d;
      ts_q <= ts_d; hcr_q <= hcr_d; first_q <= first_d; blank_q <= blank_d;
      pend_q <= pend_d; nl_sent_q <= nl_sent_d; open_rep_q <= open_rep_d;
      rep_end_q <= rep_end_d; r_q <= r_d;
    end
  end

endmodule

### hdl/mbd_outq.sv
// Output stage: holds the newest result until its last flag is known,
// then queues it for the output channel. Depends on mbd_pkg.
module mbd_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mbd_pkg::eng_out_t  eo_i,
  output logic               out_ok_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mbd_pkg::out_item_t out_item_o
);

  mbd_pkg::res_t             hold_q;
  logic                      hold_v_q, hold_fin_q;
  mbd_pkg::out_item_t        ent_q [mbd_pkg::OQ_DEPTH];
  mbd_pkg::out_item_t        push_item;
  logic [mbd_pkg::OQ_PW-1:0] wptr_q, rptr_q;
  logic [mbd_pkg::OQ_CW-1:0] cnt_q, cnt_d;
  logic                      space, push, pop, flush;

  assign space       = (cnt_q != mbd_pkg::OQ_CW'(mbd_pkg::OQ_DEPTH));
  assign out_ok_o    = !hold_v_q || space;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = ent_q[rptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // Move the held result on when a newer one arrives or its item is done
  assign flush = hold_v_q && space && !eo_i.emit && (hold_fin_q || eo_i.done);
  assign push  = (eo_i.emit && hold_v_q) || flush;
  always_comb begin
    push_item.out_byte    = hold_q.out_byte;
    push_item.region      = hold_q.region;
    push_item.event_res   = hold_q.event_res;
    push_item.closed_part = hold_q.closed_part;
    push_item.last        = eo_i.emit ? hold_fin_q : 1'b1;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (!push && pop) cnt_d = cnt_q - 1'b1;
  end

  // Queue and hold payload
  always_ff @(posedge clk_i) begin
    if (push) ent_q[wptr_q] <= push_item;
    if (eo_i.emit) hold_q <= eo_i.res;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0; hold_fin_q <= 1'b0;
      wptr_q <= '0; rptr_q <= '0; cnt_q <= '0;
    end else begin
      if (eo_i.emit) begin
        hold_v_q <= 1'b1; hold_fin_q <= eo_i.done;
      end else if (flush) begin
        hold_v_q <= 1'b0; hold_fin_q <= 1'b0;
      end else if (eo_i.done && hold_v_q) begin
        hold_fin_q <= 1'b1;
      end
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hdl/mbd_checker.sv
// Port checker for the multipart boundary deframer, bound to the top level.
// Depends on mbd_pkg and multipart_boundary_deframer_top.
module mbd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input mbd_pkg::out_item_t out_item_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output transfer changed while stalled");

  // Event results carry no byte
  a_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.region == mbd_pkg::RG_EVENT |-> out_item_o.out_byte == 8'd0)
    else $error("event result with byte");

  // Byte results carry no event
  a_byte_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.region != mbd_pkg::RG_EVENT |->
      out_item_o.event_res == mbd_pkg::EV_NONE && !out_item_o.closed_part)
    else $error("byte result with event");

  // Only boundaries and stream end close a part
  a_closed_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.closed_part |->
      out_item_o.event_res == mbd_pkg::EV_SEP || out_item_o.event_res == mbd_pkg::EV_TERM ||
      out_item_o.event_res == mbd_pkg::EV_END)
    else $error("closed part on wrong event");

endmodule

bind multipart_boundary_deframer_top mbd_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

### tb/tb.sv
// Testbench of the multipart boundary deframer: directed and random byte streams.
// Checks every result against an in-bench prediction of the deframing walk.
// Depends on mbd_pkg and multipart_boundary_deframer_top.
module tb;

  typedef logic [7:0] u8;

  localparam int NBND   = mbd_pkg::MAX_BOUNDARY_DEF;
  localparam int NSLOTS = 8;
  localparam int NTRAIL = mbd_pkg::MAX_TRAIL_SPACE_DEF;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  mbd_pkg::in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  mbd_pkg::out_item_t out_item_o;
  logic      psel = 1'b0;
  logic      penable = 1'b0;
  logic      pwrite = 1'b0;
  logic [mbd_pkg::APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  multipart_boundary_deframer_top i_dut (.*);

  always #6 clk_i = ~clk_i;

  // Predicted walk state and configuration
  int unsigned blen_reg;
  bit          nl_crlf;
  u8           bnd_mem [NBND];
  mbd_pkg::phase_e wphase;
  int unsigned mpos;
  bit          cand;
  bit          at_line_start;
  int unsigned tdash;
  int unsigned tspace;
  u8           held_sp [NSLOTS];
  bit          held_cr;
  bit          first_body;
  bit          blank_hdr;
  bit          pushed_any;

  mbd_pkg::out_item_t pending_out[$];
  int          mismatches = 0;

  // Test control
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int stall_cnt = 0;
  int rand_items = 0;
  u8  msg[$];

  // ---------------- prediction ----------------
  function automatic void emit(u8 b, logic [1:0] rg, logic [2:0] ev, bit cl);
    mbd_pkg::out_item_t r;
    r.out_byte = b;
    r.region = rg;
    r.event_res = ev;
    r.closed_part = cl;
    r.last = 1'b0;
    pending_out.push_back(r);
    pushed_any = 1'b1;
  endfunction

  function automatic int unsigned eff_blen();
    return (blen_reg > NBND) ? NBND : blen_reg;
  endfunction

  function automatic bit ws_char(u8 c);
    return c == 8'd32 || c == 8'd9 || c == 8'd11 || c == 8'd12 || c == mbd_pkg::CH_CR;
  endfunction

  function automatic void drop_candidate();
    cand = 1'b0;
    mpos = 0;
    tdash = 0;
    tspace = 0;
    held_cr = 1'b0;
  endfunction

  function automatic void begin_line(u8 first);
    if (wphase == mbd_pkg::PH_BODY) begin
      if (!first_body) begin
        if (nl_crlf) emit(mbd_pkg::CH_CR, mbd_pkg::RG_BODY, mbd_pkg::EV_NONE, 1'b0);
        emit(mbd_pkg::CH_LF, mbd_pkg::RG_BODY, mbd_pkg::EV_NONE, 1'b0);
      end
      first_body = 1'b0;
    end
    blank_hdr = (wphase == mbd_pkg::PH_HDR) &&
                (first == mbd_pkg::CH_CR || first == mbd_pkg::CH_LF);
  endfunction

  function automatic void finish_line();
    at_line_start = 1'b1;
    drop_candidate();
    if (wphase == mbd_pkg::PH_HDR && blank_hdr) begin
      emit(8'd0, mbd_pkg::RG_EVENT, mbd_pkg::EV_HDRS, 1'b0);
      wphase = mbd_pkg::PH_BODY;
      first_body = 1'b1;
    end
    blank_hdr = 1'b0;
  endfunction

  function automatic void line_byte(u8 c);
    case (wphase)
      mbd_pkg::PH_HDR: begin
        emit(c, mbd_pkg::RG_HDR, mbd_pkg::EV_NONE, 1'b0);
        if (c == mbd_pkg::CH_LF) finish_line();
      end
      mbd_pkg::PH_BODY: begin
        if (held_cr) begin
          if (c == mbd_pkg::CH_LF) begin
            finish_line();
            return;
          end
          emit(mbd_pkg::CH_CR, mbd_pkg::RG_BODY, mbd_pkg::EV_NONE, 1'b0);
          held_cr = 1'b0;
        end
        if (c == mbd_pkg::CH_LF) finish_line();
        else if (c == mbd_pkg::CH_CR) held_cr = 1'b1;
        else emit(c, mbd_pkg::RG_BODY, mbd_pkg::EV_NONE, 1'b0);
      end
      mbd_pkg::PH_PRE: if (c == mbd_pkg::CH_LF) finish_line();
      default: ;
    endcase
  endfunction

  // Give back the bytes of a failed boundary match as ordinary line bytes
  function automatic void replay_held();
    int unsigned mp, nd, ns;
    bit cr;
    mp = mpos;
    nd = tdash;
    ns = tspace;
    cr = held_cr;
    drop_candidate();
    begin_line(mbd_pkg::CH_DASH);
    for (int unsigned i = 0; i < mp; i++)
      line_byte(i < 2 ? mbd_pkg::CH_DASH : bnd_mem[i-2]);
    for (int unsigned i = 0; i < nd; i++) line_byte(mbd_pkg::CH_DASH);
    for (int unsigned i = 0; i < ns && i < NSLOTS; i++) line_byte(held_sp[i]);
    if (cr) line_byte(mbd_pkg::CH_CR);
  endfunction

  function automatic void take_boundary();
    bit term;
    term = (tdash == 2);
    emit(8'd0, mbd_pkg::RG_EVENT, term ? mbd_pkg::EV_TERM : mbd_pkg::EV_SEP,
         wphase != mbd_pkg::PH_PRE);
    drop_candidate();
    at_line_start = 1'b1;
    blank_hdr = 1'b0;
    wphase = term ? mbd_pkg::PH_EPI : mbd_pkg::PH_HDR;
  endfunction

  function automatic bit hold_space(u8 b);
    if (tspace < NTRAIL && tspace < NSLOTS) begin
      held_sp[tspace] = b;
      tspace++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void match_byte(u8 c);
    u8  want;
    bit ok;
    if (mpos < eff_blen() + 2) begin
      want = (mpos >= 2) ? bnd_mem[mpos-2] : mbd_pkg::CH_DASH;
      if (c == want) begin
        mpos++;
        return;
      end
    end else if (c == mbd_pkg::CH_DASH && tdash < 2 && tspace == 0 && !held_cr) begin
      tdash++;
      return;
    end else if (c == mbd_pkg::CH_LF) begin
      if (tdash != 1) begin
        take_boundary();
        return;
      end
    end else if (ws_char(c) && tdash != 1) begin
      ok = 1'b1;
      if (held_cr) begin
        ok = hold_space(mbd_pkg::CH_CR);
        if (ok) held_cr = 1'b0;
      end
      if (ok) begin
        if (c == mbd_pkg::CH_CR) begin
          held_cr = 1'b1;
          return;
        end
        if (hold_space(c)) return;
      end
    end
    replay_held();
    line_byte(c);
  endfunction

  function automatic void stream_byte(u8 c);
    if (wphase == mbd_pkg::PH_EPI) return;
    if (at_line_start) begin
      at_line_start = 1'b0;
      if (eff_blen() != 0 && c == mbd_pkg::CH_DASH) begin
        drop_candidate();
        cand = 1'b1;
        mpos = 1;
        return;
      end
      begin_line(c);
      line_byte(c);
    end else if (cand) begin
      match_byte(c);
    end else begin
      line_byte(c);
    end
  endfunction

  function automatic void stream_end();
    if (wphase != mbd_pkg::PH_EPI && !at_line_start) begin
      if (cand) begin
        if (mpos >= eff_blen() + 2 && tdash != 1) take_boundary();
        else replay_held();
      end
      if (!at_line_start) finish_line();
    end
    emit(8'd0, mbd_pkg::RG_EVENT, mbd_pkg::EV_END, wphase == mbd_pkg::PH_BODY);
    wphase = mbd_pkg::PH_PRE;
    at_line_start = 1'b1;
    drop_candidate();
    first_body = 1'b1;
    blank_hdr = 1'b0;
  endfunction

  // Expected results of one accepted item
  function automatic void deframe_item(mbd_pkg::in_item_t it);
    pushed_any = 1'b0;
    case (it.operation)
      mbd_pkg::OP_LOAD:
        if (it.boundary_index < NBND) bnd_mem[it.boundary_index] = it.data_byte;
      mbd_pkg::OP_BYTE: stream_byte(it.data_byte);
      mbd_pkg::OP_END:  stream_end();
      default: ;
    endcase
    if (pushed_any) pending_out[pending_out.size()-1].last = 1'b1;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_item(logic [1:0] op, u8 data, logic [5:0] idx);
    mbd_pkg::in_item_t it;
    it.operation = op;
    it.data_byte = data;
    it.boundary_index = idx;
    @(negedge clk_i);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    deframe_item(it);
  endtask

  task automatic send_msg();
    foreach (msg[i]) send_item(mbd_pkg::OP_BYTE, msg[i], 6'd0);
    rand_items += msg.size();
    msg.delete();
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(u8'(s[i]));
  endtask

  task automatic write_reg(logic [mbd_pkg::APB_AW-1:0] addr, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drop valid, wait for all results, then for trailing work of result-free items
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned blen, bit crlf);
    settle();
    write_reg({mbd_pkg::REG_BLEN, 2'b00}, blen);
    write_reg({mbd_pkg::REG_NLMODE, 2'b00}, 32'(crlf));
    blen_reg = blen & 63;
    nl_crlf = crlf;
  endtask

  // ---------------- stimulus builders ----------------
  task automatic add_boundary(bit term, bit broken);
    int unsigned n;
    int unsigned cut;
    n = eff_blen();
    cut = (broken && n > 0 && $urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : n;
    msg.push_back(mbd_pkg::CH_DASH);
    msg.push_back(mbd_pkg::CH_DASH);
    for (int unsigned i = 0; i < cut; i++) msg.push_back(bnd_mem[i]);
    if (broken && cut == n) begin
      if ($urandom_range(0, 1)) msg.push_back(mbd_pkg::CH_DASH);
      else add_str(" \t");
    end else if (term) begin
      add_str("--");
    end
    if ($urandom_range(0, 2) == 0) msg.push_back(u8'($urandom_range(0, 1) ? 32 : 9));
    if ($urandom_range(0, 1)) msg.push_back(mbd_pkg::CH_CR);
    msg.push_back(mbd_pkg::CH_LF);
  endtask

  task automatic add_text(bit hdr);
    int unsigned n;
    n = $urandom_range(0, 6);
    if (hdr) add_str("X-k: ");
    repeat (n) begin
      case ($urandom_range(0, 7))
        0: msg.push_back(u8'($urandom_range(0, 255)));
        1: msg.push_back(mbd_pkg::CH_DASH);
        2: msg.push_back(8'd32);
        3: msg.push_back(mbd_pkg::CH_CR);
        default: msg.push_back(u8'(8'd97 + $urandom_range(0, 25)));
      endcase
    end
    if ($urandom_range(0, 1)) msg.push_back(mbd_pkg::CH_CR);
    msg.push_back(mbd_pkg::CH_LF);
  endtask

  // One multipart stream: mostly well formed, some noise and cut-off streams
  task automatic gen_stream();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0: add_text(1'b0);
          1: add_boundary($urandom_range(0, 1), 1'b1);
          default: add_boundary(1'b0, 1'b0);
        endcase
      end
      if ($urandom_range(0, 1)) begin
        add_str("--");
        for (int unsigned i = 0; i < eff_blen(); i++) msg.push_back(bnd_mem[i]);
      end
    end else begin
      repeat ($urandom_range(0, 1)) add_text(1'b0);
      repeat ($urandom_range(1, 2)) begin
        add_boundary(1'b0, 1'b0);
        repeat ($urandom_range(0, 2)) add_text(1'b1);
        add_str($urandom_range(0, 1) ? "\r\n" : "\n");
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 4) == 0) add_boundary($urandom_range(0, 1), 1'b1);
          else add_text(1'b0);
        end
      end
      if ($urandom_range(0, 4) != 0) begin
        add_boundary(1'b1, 1'b0);
        if ($urandom_range(0, 1)) add_text(1'b0);
      end
    end
    send_msg();
    if ($urandom_range(0, 6) != 0) send_item(mbd_pkg::OP_END, u8'($urandom), 6'd0);
  endtask

  task automatic load_boundary(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_item(mbd_pkg::OP_LOAD, u8'(8'd65 + $urandom_range(0, 25)), 6'(i));
  endtask

  // ---------------- tests ----------------
  task automatic test_reset_defaults();
    // boundary length 0 after reset: nothing matches, preamble is dropped
    add_str("--\r\n");
    send_msg();
    send_item(mbd_pkg::OP_END, 8'd0, 6'd0);
  endtask

  task automatic test_boundary_load();
    for (int i = 0; i < 8; i++) send_item(mbd_pkg::OP_LOAD, u8'(8'd97 + i), 6'(i));
    send_item(mbd_pkg::OP_LOAD, 8'hFF, 6'd50);
    send_item(mbd_pkg::OP_LOAD, 8'h00, 6'd63);
    send_item(2'd3, 8'hA5, 6'd0);
  endtask

  task automatic test_directed();
    configure(2, 1'b1);
    add_str("--ab \r\n");
    add_str("\r\n");
    add_str("x\r\n-\n");
    add_str("--ab-\n");
    add_str("--ab--\n");
    send_msg();
    send_item(mbd_pkg::OP_END, 8'd0, 6'd0);
    // cut off mid-line with a complete boundary pending
    add_str("--ab\n\n--ab");
    send_msg();
    send_item(mbd_pkg::OP_END, 8'd0, 6'd0);
  endtask

  task automatic test_backpressure();
    configure(2, 1'b0);
    hold_req = 1'b1;
    add_str("--ab\n\n");
    repeat (12) msg.push_back(u8'(8'd97 + $urandom_range(0, 25)));
    add_str("\n--ab--\n");
    send_msg();
    send_item(mbd_pkg::OP_END, 8'd0, 6'd0);
  endtask

  task automatic run_phase(int unsigned blen, bit crlf, int target);
    configure(blen, crlf);
    load_boundary(blen > NBND ? NBND : blen);
    target += rand_items;
    do gen_stream(); while (rand_items < target);
  endtask

  task automatic test_random();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_phase(4, 1'b0, 30);
    run_phase(1, 1'b1, 25);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_phase(6, 1'b1, 25);
  endtask

  // ---------------- receiver ----------------
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (rx_idle && $urandom_range(0, 5) == 0) stall_cnt = $urandom_range(1, 15);
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk_i) begin
    mbd_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item_o);
      end else begin
        want = pending_out.pop_front();
        if (out_item_o.out_byte !== want.out_byte || out_item_o.region !== want.region ||
            out_item_o.event_res !== want.event_res ||
            out_item_o.closed_part !== want.closed_part || out_item_o.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, out_item_o);
        end
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    blen_reg = 0;
    nl_crlf = 1'b1;
    foreach (bnd_mem[i]) bnd_mem[i] = 8'd0;
    foreach (held_sp[i]) held_sp[i] = 8'd0;
    wphase = mbd_pkg::PH_PRE;
    at_line_start = 1'b1;
    drop_candidate();
    first_body = 1'b1;
    blank_hdr = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_boundary_load();
    test_directed();
    test_backpressure();
    test_random();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Timeout
  initial begin
    #(12 * 3000000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
